>>> src/data_processing_alu_barrel_shift_assert.svh
// Assertion macros for the data-processing ALU block.
// No dependencies; included by the checker module.
`ifndef DATA_PROCESSING_ALU_BARREL_SHIFT_ASSERT_SVH
`define DATA_PROCESSING_ALU_BARREL_SHIFT_ASSERT_SVH

// Implication check, sampled on clk, off while rst is high
`define DPABS_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, also evaluated during reset
`define DPABS_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/dpabs_pkg.sv
// Shared types for the data-processing ALU and barrel shifter.
// No dependencies; imported by every module of the block.
`default_nettype none

package dpabs_pkg;

  // Input word: one data-processing instruction and its operands
  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] rn_value;
    logic [31:0] rm_value;
    logic [7:0]  rs_value;
    logic [3:0]  flags_in;
  } dpabs_in_t;

  // Result word
  typedef struct packed {
    logic [31:0] result_value;
    logic [3:0]  dest_reg;
    logic        write_dest;
    logic [3:0]  flags_out;
  } dpabs_out_t;

  // Shift type field, instruction bits 6:5
  typedef enum logic [1:0] {
    ST_LSL = 2'd0,
    ST_LSR = 2'd1,
    ST_ASR = 2'd2,
    ST_ROR = 2'd3
  } sh_type_t;

  // Normalized shifter operation after decode
  typedef enum logic [2:0] {
    SH_PASS,
    SH_LSL,
    SH_LSR,
    SH_ASR,
    SH_ROR,
    SH_ZERO,
    SH_SIGN,
    SH_RRX
  } sh_kind_t;

  // Shifter control: amt is 1..31 for the real shifts
  typedef struct packed {
    sh_kind_t   kind;
    logic [4:0] amt;
    logic       fixed_c;
  } shctl_t;

  // Opcode field, instruction bits 24:21
  typedef enum logic [3:0] {
    OPC_AND = 4'h0,
    OPC_EOR = 4'h1,
    OPC_SUB = 4'h2,
    OPC_RSB = 4'h3,
    OPC_ADD = 4'h4,
    OPC_ADC = 4'h5,
    OPC_SBC = 4'h6,
    OPC_RSC = 4'h7,
    OPC_TST = 4'h8,
    OPC_TEQ = 4'h9,
    OPC_CMP = 4'hA,
    OPC_CMN = 4'hB,
    OPC_ORR = 4'hC,
    OPC_MOV = 4'hD,
    OPC_BIC = 4'hE,
    OPC_MVN = 4'hF
  } opc_t;

  // Flag bit positions in NZCV
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

endpackage

`default_nettype wire

>>> src/dpabs_shifter.sv
// Barrel shifter datapath: applies a decoded shift and produces carry-out.
// Depends on dpabs_pkg for the shifter control type.
`default_nettype none

module dpabs_shifter (
  input  logic [31:0]       value,
  input  dpabs_pkg::shctl_t ctl,
  input  logic              cin,
  output logic [31:0]       result,
  output logic              carry
);
  import dpabs_pkg::*;

  // extended shifts keep the last bit shifted out next to the result
  logic [32:0] lsl_ext;
  logic [32:0] lsr_ext;
  logic [32:0] asr_ext;
  logic [63:0] ror_ext;

  assign lsl_ext = {1'b0, value} << ctl.amt;
  assign lsr_ext = {value, 1'b0} >> ctl.amt;
  assign asr_ext = $signed({value, 1'b0}) >>> ctl.amt;
  assign ror_ext = {value, value} >> ctl.amt;

  always_comb begin
    unique case (ctl.kind)
      SH_LSL: begin
        result = lsl_ext[31:0];
        carry  = lsl_ext[32];
      end
      SH_LSR: begin
        result = lsr_ext[32:1];
        carry  = lsr_ext[0];
      end
      SH_ASR: begin
        result = asr_ext[32:1];
        carry  = asr_ext[0];
      end
      SH_ROR: begin
        result = ror_ext[31:0];
        carry  = ror_ext[31];
      end
      SH_ZERO: begin
        result = '0;
        carry  = ctl.fixed_c;
      end
      SH_SIGN: begin
        result = {32{value[31]}};
        carry  = ctl.fixed_c;
      end
      SH_RRX: begin
        result = {cin, value[31:1]};
        carry  = value[0];
      end
      SH_PASS: begin
        result = value;
        carry  = ctl.fixed_c;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/data_processing_alu_barrel_shift.sv
// Stages: decode, shift, add/logic, flags; an accepted op word passes each
// in turn into res_data. One word per cycle while the output is not stalled.
// Each stage holds while the stage after it is full and stalled, so op_stall
// is high only while every stage and the output register are full.
// Reset (rst, synchronous) clears all stage valid bits; no other state.
`default_nettype none

module data_processing_alu_barrel_shift (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 op_valid,
  output logic                 op_stall,
  input  dpabs_pkg::dpabs_in_t op_data,
  output logic                 res_valid,
  input  logic                 res_stall,
  output dpabs_pkg::dpabs_out_t res_data
);
  import dpabs_pkg::*;

  // decode stage register
  typedef struct packed {
    logic [31:0] op1;
    logic [31:0] value;
    shctl_t      ctl;
    opc_t        opc;
    logic        s;
    logic [3:0]  rd;
    logic [3:0]  flags;
  } dec_stage_t;

  // shift stage register
  typedef struct packed {
    logic [31:0] op1;
    logic [31:0] op2;
    logic        sc;
    opc_t        opc;
    logic        s;
    logic [3:0]  rd;
    logic [3:0]  flags;
  } sh_stage_t;

  // ALU stage register
  typedef struct packed {
    logic [31:0] res;
    logic        ac;
    logic        av;
    logic        sc;
    logic        logical;
    logic        wr;
    logic        upd;
    logic [3:0]  rd;
    logic [3:0]  flags;
  } alu_stage_t;

  logic       s1_valid, s2_valid, s3_valid;
  dec_stage_t s1, s1_next;
  sh_stage_t  s2, s2_next;
  alu_stage_t s3, s3_next;
  dpabs_out_t res_next;

  logic rdy_o, rdy3, rdy2, rdy1;

  // stage advance: a stage loads when it is empty or its word moves on
  assign rdy_o    = !res_valid || !res_stall;
  assign rdy3     = !s3_valid || rdy_o;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign op_stall = !rdy1;

  // decode: operand 2 source and normalized shift
  logic [31:0] ins;
  logic        cin;
  logic [4:0]  imm_amt;
  logic [7:0]  rs;
  shctl_t      dec_ctl;
  logic [31:0] dec_val;

  assign ins     = op_data.instruction;
  assign cin     = op_data.flags_in[FLAG_C];
  assign imm_amt = ins[11:7];
  assign rs      = op_data.rs_value;

  always_comb begin
    dec_ctl = '{kind: SH_PASS, amt: 5'd0, fixed_c: cin};
    dec_val = op_data.rm_value;
    if (ins[25]) begin
      // rotated immediate; rotation of zero keeps carry
      dec_val = {24'd0, ins[7:0]};
      if (ins[11:8] != 4'd0) begin
        dec_ctl.kind = SH_ROR;
        dec_ctl.amt  = {ins[11:8], 1'b0};
      end
    end else if (ins[4]) begin
      // register-specified amount; zero passes Rm and keeps carry
      if (rs != 8'd0) begin
        unique case (sh_type_t'(ins[6:5]))
          ST_LSL: begin
            if (rs[7:5] == 3'd0) begin
              dec_ctl.kind = SH_LSL;
              dec_ctl.amt  = rs[4:0];
            end else begin
              dec_ctl.kind    = SH_ZERO;
              dec_ctl.fixed_c = (rs == 8'd32) && op_data.rm_value[0];
            end
          end
          ST_LSR: begin
            if (rs[7:5] == 3'd0) begin
              dec_ctl.kind = SH_LSR;
              dec_ctl.amt  = rs[4:0];
            end else begin
              dec_ctl.kind    = SH_ZERO;
              dec_ctl.fixed_c = (rs == 8'd32) && op_data.rm_value[31];
            end
          end
          ST_ASR: begin
            if (rs[7:5] == 3'd0) begin
              dec_ctl.kind = SH_ASR;
              dec_ctl.amt  = rs[4:0];
            end else begin
              dec_ctl.kind    = SH_SIGN;
              dec_ctl.fixed_c = op_data.rm_value[31];
            end
          end
          ST_ROR: begin
            if (rs[4:0] != 5'd0) begin
              dec_ctl.kind = SH_ROR;
              dec_ctl.amt  = rs[4:0];
            end else begin
              // multiple of 32: value unchanged, carry from bit 31
              dec_ctl.fixed_c = op_data.rm_value[31];
            end
          end
        endcase
      end
    end else begin
      // immediate amount; zero has special meanings per type
      unique case (sh_type_t'(ins[6:5]))
        ST_LSL: begin
          if (imm_amt != 5'd0) begin
            dec_ctl.kind = SH_LSL;
            dec_ctl.amt  = imm_amt;
          end
        end
        ST_LSR: begin
          if (imm_amt != 5'd0) begin
            dec_ctl.kind = SH_LSR;
            dec_ctl.amt  = imm_amt;
          end else begin
            dec_ctl.kind    = SH_ZERO;
            dec_ctl.fixed_c = op_data.rm_value[31];
          end
        end
        ST_ASR: begin
          if (imm_amt != 5'd0) begin
            dec_ctl.kind = SH_ASR;
            dec_ctl.amt  = imm_amt;
          end else begin
            dec_ctl.kind    = SH_SIGN;
            dec_ctl.fixed_c = op_data.rm_value[31];
          end
        end
        ST_ROR: begin
          if (imm_amt != 5'd0) begin
            dec_ctl.kind = SH_ROR;
            dec_ctl.amt  = imm_amt;
          end else begin
            dec_ctl.kind = SH_RRX;
          end
        end
      endcase
    end
  end

  always_comb begin
    s1_next.op1   = op_data.rn_value;
    s1_next.value = dec_val;
    s1_next.ctl   = dec_ctl;
    s1_next.opc   = opc_t'(ins[24:21]);
    s1_next.s     = ins[20];
    s1_next.rd    = ins[15:12];
    s1_next.flags = op_data.flags_in;
  end

  // shift stage
  logic [31:0] sh_result;
  logic        sh_carry;

  dpabs_shifter u_shifter (
    .value  (s1.value),
    .ctl    (s1.ctl),
    .cin    (s1.flags[FLAG_C]),
    .result (sh_result),
    .carry  (sh_carry)
  );

  always_comb begin
    s2_next.op1   = s1.op1;
    s2_next.op2   = sh_result;
    s2_next.sc    = sh_carry;
    s2_next.opc   = s1.opc;
    s2_next.s     = s1.s;
    s2_next.rd    = s1.rd;
    s2_next.flags = s1.flags;
  end

  // ALU stage: one 33-bit add or a logic op
  logic [31:0] alu_a, alu_b, lres;
  logic        alu_ci, is_arith, is_test;
  logic [32:0] sum;

  always_comb begin
    alu_a    = s2.op1;
    alu_b    = s2.op2;
    alu_ci   = 1'b0;
    is_arith = 1'b1;
    lres     = '0;
    unique case (s2.opc)
      OPC_AND, OPC_TST: begin
        is_arith = 1'b0;
        lres     = s2.op1 & s2.op2;
      end
      OPC_EOR, OPC_TEQ: begin
        is_arith = 1'b0;
        lres     = s2.op1 ^ s2.op2;
      end
      OPC_SUB, OPC_CMP: begin
        alu_b  = ~s2.op2;
        alu_ci = 1'b1;
      end
      OPC_RSB: begin
        alu_a  = s2.op2;
        alu_b  = ~s2.op1;
        alu_ci = 1'b1;
      end
      OPC_ADD, OPC_CMN: begin
        alu_ci = 1'b0;
      end
      OPC_ADC: begin
        alu_ci = s2.flags[FLAG_C];
      end
      OPC_SBC: begin
        alu_b  = ~s2.op2;
        alu_ci = s2.flags[FLAG_C];
      end
      OPC_RSC: begin
        alu_a  = s2.op2;
        alu_b  = ~s2.op1;
        alu_ci = s2.flags[FLAG_C];
      end
      OPC_ORR: begin
        is_arith = 1'b0;
        lres     = s2.op1 | s2.op2;
      end
      OPC_MOV: begin
        is_arith = 1'b0;
        lres     = s2.op2;
      end
      OPC_BIC: begin
        is_arith = 1'b0;
        lres     = s2.op1 & ~s2.op2;
      end
      OPC_MVN: begin
        is_arith = 1'b0;
        lres     = ~s2.op2;
      end
    endcase
  end

  assign sum     = {1'b0, alu_a} + {1'b0, alu_b} + {32'd0, alu_ci};
  assign is_test = (s2.opc == OPC_TST) || (s2.opc == OPC_TEQ) ||
                   (s2.opc == OPC_CMP) || (s2.opc == OPC_CMN);

  always_comb begin
    s3_next.res     = is_arith ? sum[31:0] : lres;
    s3_next.ac      = sum[32];
    s3_next.av      = (alu_a[31] ^ sum[31]) & (alu_b[31] ^ sum[31]);
    s3_next.sc      = s2.sc;
    s3_next.logical = !is_arith;
    s3_next.wr      = !is_test;
    s3_next.upd     = s2.s || is_test;
    s3_next.rd      = s2.rd;
    s3_next.flags   = s2.flags;
  end

  // flag stage
  always_comb begin
    res_next.result_value = s3.res;
    res_next.dest_reg     = s3.rd;
    res_next.write_dest   = s3.wr;
    res_next.flags_out    = s3.flags;
    if (s3.upd) begin
      res_next.flags_out[FLAG_N] = s3.res[31];
      res_next.flags_out[FLAG_Z] = (s3.res == 32'd0);
      res_next.flags_out[FLAG_C] = s3.logical ? s3.sc : s3.ac;
      res_next.flags_out[FLAG_V] = s3.logical ? s3.flags[FLAG_V] : s3.av;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (rdy1) s1_valid <= op_valid;
      if (rdy2) s2_valid <= s1_valid;
      if (rdy3) s3_valid <= s2_valid;
      if (rdy_o) res_valid <= s3_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1) s1 <= s1_next;
    if (rdy2) s2 <= s2_next;
    if (rdy3) s3 <= s3_next;
    if (rdy_o) res_data <= res_next;
  end

endmodule

`default_nettype wire

>>> src/dpabs_checker.sv
// Port-level checks for the data-processing ALU block, bound to its top level.
// Depends on dpabs_pkg and the assertion macro header.
`default_nettype none

`include "data_processing_alu_barrel_shift_assert.svh"

module dpabs_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  op_valid,
  input logic                  op_stall,
  input logic                  res_valid,
  input logic                  res_stall,
  input dpabs_pkg::dpabs_out_t res_data
);
  import dpabs_pkg::*;

  // no result word right after reset
  `DPABS_CHECK_ALWAYS(a_reset_empty, $past(rst) |-> !res_valid, "result valid after reset")

  // a stalled result word holds
  `DPABS_CHECK(a_res_hold, res_valid && res_stall |=> res_valid && $stable(res_data), "result word changed under stall")

  // input side backs up only when the output register is full
  `DPABS_CHECK(a_stall_full, op_stall |-> res_valid, "op stalled with empty output")

  // with the output flowing, an accepted word passes every stage to res_valid
  `DPABS_CHECK(a_latency, (op_valid && !op_stall) ##1 !res_stall ##1 !res_stall ##1 !res_stall |=> res_valid, "result missing after pipeline latency")

endmodule

bind data_processing_alu_barrel_shift dpabs_checker u_dpabs_checker (.*);

`default_nettype wire
